>>> hw/rtl/timestamp_pair_ring_nearest_match_top_defines.svh
// assertion macros for the timestamp pair ring checker
`ifndef TIMESTAMP_PAIR_RING_NEAREST_MATCH_TOP_DEFINES_SVH
`define TIMESTAMP_PAIR_RING_NEAREST_MATCH_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define TSNM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define TSNM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// what must hold in the cycle after reset is seen
`define TSNM_ASSERT_RST(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tsnm_pkg.sv
// shared types and constants for the timestamp pair ring
package tsnm_pkg;

   localparam int TIME_W        = 62;
   localparam int TOL_W         = 20;
   localparam int DEPTH_DEFAULT = 256;
   localparam logic [TOL_W-1:0] TOL_RESET = 20'd1000;

   typedef enum logic [1:0] {
      MODE_CALLBACK = 2'd0,
      MODE_PRESENT  = 2'd1,
      MODE_FIND     = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] present_us;
      logic [TIME_W-1:0] callback_us;
      logic              generated;
   } pair_type;

   typedef struct packed {
      logic done;
      logic found;
   } walk_stat_type;

endpackage

>>> hw/rtl/tsnm_pair_ram.sv
// pair store: one write port, one registered read port
module tsnm_pair_ram
   import tsnm_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  pair_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output pair_type      rd_data
);

   pair_type mem_ff [DEPTH];
   pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tsnm_walk.sv
// backward walk over the ring, one entry read per cycle, keeps the nearest match
module tsnm_walk
   import tsnm_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] query,
   input  logic [TOL_W-1:0]  tol,
   input  logic [AW-1:0]     wp,
   input  logic [CW-1:0]     live,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   input  pair_type          rd_data,
   output walk_stat_type     stat,
   output pair_type          result
);

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic              active_ff, done_ff, stop_ff, pend_ff, found_ff;
   logic [AW-1:0]     addr_ff;
   logic [CW-1:0]     rem_ff;
   logic [TOL_W:0]    best_ff;
   logic [TIME_W-1:0] query_ff;
   pair_type          res_ff;

   logic [TIME_W:0]   a_diff;
   logic [TIME_W-1:0] b_diff, gap;
   logic              p_later, too_old, closer, eval, brk, take, finish, issue;
   logic [AW-1:0]     addr_dec, start_addr;

   always_comb begin
      a_diff  = {1'b0, query_ff} - {1'b0, rd_data.present_us};
      b_diff  = rd_data.present_us - query_ff;
      p_later = a_diff[TIME_W];
      gap     = p_later ? b_diff : a_diff[TIME_W-1:0];
      // present plus tolerance below the query ends the walk
      too_old = !p_later && (a_diff[TIME_W-1:0] > {{(TIME_W-TOL_W){1'b0}}, tol});
      closer  = (gap[TIME_W-1:TOL_W+1] == '0) && (gap[TOL_W:0] < best_ff);
      eval    = pend_ff && !stop_ff;
      brk     = eval && too_old;
      take    = eval && !too_old && closer;
      finish  = active_ff && (stop_ff || ((rem_ff == '0) && !pend_ff));
      issue   = active_ff && (rem_ff != '0) && !stop_ff && !brk;
      addr_dec   = (addr_ff == '0) ? LAST : addr_ff - 1'b1;
      start_addr = (wp == '0) ? LAST : wp - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         stop_ff   <= 1'b0;
         pend_ff   <= 1'b0;
      end else if (start) begin
         active_ff <= 1'b1;
         done_ff   <= 1'b0;
         stop_ff   <= 1'b0;
         pend_ff   <= 1'b0;
      end else if (active_ff) begin
         pend_ff <= issue;
         if (brk) begin
            stop_ff <= 1'b1;
         end
         if (finish) begin
            active_ff <= 1'b0;
            done_ff   <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         addr_ff  <= start_addr;
         rem_ff   <= live;
         best_ff  <= {1'b0, tol} + 1'b1;
         found_ff <= 1'b0;
         res_ff   <= '0;
         query_ff <= query;
      end else if (active_ff) begin
         if (issue) begin
            addr_ff <= addr_dec;
            rem_ff  <= rem_ff - 1'b1;
         end
         // strict compare keeps the newer entry on a tie
         if (take) begin
            best_ff  <= gap[TOL_W:0];
            found_ff <= 1'b1;
            res_ff   <= rd_data;
         end
      end
   end

   assign rd_en      = issue;
   assign rd_addr    = addr_ff;
   assign stat.done  = done_ff;
   assign stat.found = found_ff;
   assign result     = res_ff;

endmodule

>>> hw/rtl/timestamp_pair_ring_nearest_match_top.sv
// top level of the timestamp pair ring with nearest-time lookup
//
// req_ beats carry mode, time_us and generated_flag. A callback beat stages
// a time and flag, a present beat commits the staged pair into the next ring
// slot when the staged time is nonzero and not later than the present time,
// a clear beat drops all stored pairs and the staging. These beats
// give no rsp_ beat.
// A find beat gives one rsp_ beat. It reads back one stored pair per cycle
// from the newest, over the pairs committed since the last clear (at most
// DEPTH); it ends early at the first pair older than the query minus the
// tolerance.
// Live pairs are tracked by a count since ring order makes the newest ones
// the only live ones, so no clearing pass runs after reset.
// csr_ beats write tolerance_us (reset 1000); write only while idle.
// Reset empties the ring and the staging and drops any pending rsp_ beat.
// A stalled rsp_ beat holds; a finished find waits for it before handing
// over, while req_ stays closed until then.
module timestamp_pair_ring_nearest_match_top
   import tsnm_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic [TIME_W-1:0] req_time_us,
   input  logic              req_generated_flag,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic [TIME_W-1:0] rsp_match_present_us,
   output logic [TIME_W-1:0] rsp_match_callback_us,
   output logic              rsp_match_generated,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TOL_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   state_type         state_ff, state_in;
   logic [TOL_W-1:0]  tol_ff;
   logic [AW-1:0]     wp_ff;
   logic [CW-1:0]     live_ff;
   logic [TIME_W-1:0] staged_ff;
   logic              staged_gen_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   pair_type          rsp_pair_ff;
   logic              rsp_found_ff;

   logic          req_fire, commit, find_start, load;
   mode_type      mode;
   pair_type      wr_data, rd_data, walk_res;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   walk_stat_type walk_stat;

   assign mode       = mode_type'(req_mode);
   assign req_ready  = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_valid && req_ready;
   assign commit     = req_fire && (mode == MODE_PRESENT) && (staged_ff != '0)
                       && (req_time_us >= staged_ff);
   assign find_start = req_fire && (mode == MODE_FIND);
   assign wr_data    = '{present_us: req_time_us, callback_us: staged_ff,
                         generated: staged_gen_ff};

   always_comb begin
      state_in     = state_ff;
      load         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (find_start) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_stat.done && (!rsp_valid_ff || rsp_ready)) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         tol_ff        <= TOL_RESET;
         wp_ff         <= '0;
         live_ff       <= '0;
         staged_ff     <= '0;
         staged_gen_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            tol_ff <= csr_wdata;
         end
         if (req_fire) begin
            case (mode)
               MODE_CALLBACK: begin
                  staged_ff     <= req_time_us;
                  staged_gen_ff <= req_generated_flag;
               end
               MODE_PRESENT: begin
                  if (commit) begin
                     wp_ff     <= (wp_ff == LAST) ? '0 : wp_ff + 1'b1;
                     staged_ff <= '0;
                     if (live_ff != FULL) begin
                        live_ff <= live_ff + 1'b1;
                     end
                  end
               end
               MODE_CLEAR: begin
                  live_ff       <= '0;
                  staged_ff     <= '0;
                  staged_gen_ff <= 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_found_ff <= walk_stat.found;
         rsp_pair_ff  <= walk_res;
      end
   end

   tsnm_pair_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tsnm_walk #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_walk (
      .clock   (clock),
      .reset   (reset),
      .start   (find_start),
      .query   (req_time_us),
      .tol     (tol_ff),
      .wp      (wp_ff),
      .live    (live_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .stat    (walk_stat),
      .result  (walk_res)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_found             = rsp_found_ff;
   assign rsp_match_present_us  = rsp_pair_ff.present_us;
   assign rsp_match_callback_us = rsp_pair_ff.callback_us;
   assign rsp_match_generated   = rsp_pair_ff.generated;

endmodule

>>> hw/rtl/tsnm_checker.sv
// port-level checks for the timestamp pair ring, bound to the top level
`include "timestamp_pair_ring_nearest_match_top_defines.svh"

module tsnm_checker
   import tsnm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_found,
   input logic [TIME_W-1:0] rsp_match_present_us,
   input logic [TIME_W-1:0] rsp_match_callback_us,
   input logic              rsp_match_generated
);

   // a stalled result beat holds
   `TSNM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_found) && $stable(rsp_match_present_us)
         && $stable(rsp_match_callback_us),
      "rsp beat changed while stalled")

   // a miss carries all-zero fields
   `TSNM_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_found,
      (rsp_match_present_us == '0) && (rsp_match_callback_us == '0) && !rsp_match_generated,
      "miss with nonzero fields")

   // stored pairs never have the present time before the callback time
   `TSNM_ASSERT_NOW(a_pair_order, clock, reset, rsp_valid && rsp_found,
      (rsp_match_present_us >= rsp_match_callback_us) && (rsp_match_callback_us != '0),
      "matched pair out of order")

   // reset drops any pending result
   `TSNM_ASSERT_RST(a_reset_empty, clock, reset, !rsp_valid, "rsp valid after reset")

endmodule

bind timestamp_pair_ring_nearest_match_top tsnm_checker u_tsnm_checker (.*);
